FILE: hw/rtl/itda_pkg.sv
package itda_pkg;

   // Character codes
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // Width of the digit position counter, follows the min_digits field
   localparam int unsigned POS_W = 6;

   typedef struct packed {
      logic [63:0]      value;
      logic             signed_mode;
      logic [POS_W-1:0] min_digits;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   // Sequencer to converter
   typedef struct packed {
      logic load;
      logic shift_digit;
   } dab_ctl_type;

   // Converter to sequencer
   typedef struct packed {
      logic       done;
      logic [3:0] top_digit;
   } dab_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_DIGITS
   } emit_state_type;

endpackage

FILE: hw/rtl/itda_dabble.sv
module itda_dabble #(
   parameter int unsigned VALUE_WIDTH = 64,
   parameter int unsigned NUM_DIGITS  = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  itda_pkg::dab_ctl_type    ctl,
   input  logic [VALUE_WIDTH-1:0]   mag,
   output itda_pkg::dab_stat_type   stat
);
   import itda_pkg::*;

   localparam int unsigned BCD_W = 4 * NUM_DIGITS;
   localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   // Add three to every digit of five or more before the doubling shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Load, shift one binary bit in per cycle, then shift digits out from the top
   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (ctl.load) begin
         mag_in = mag;
         bcd_in = '0;
         cnt_in = CNT_W'(VALUE_WIDTH);
      end else if (cnt_ff != '0) begin
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         cnt_in = cnt_ff - CNT_W'(1);
      end else if (ctl.shift_digit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign stat.done      = (cnt_ff == '0);
   assign stat.top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

FILE: hw/rtl/itda_emit.sv
module itda_emit #(
   parameter int unsigned NUM_DIGITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             neg,
   input  logic [itda_pkg::POS_W-1:0]       min_digits,
   output logic                             idle,
   output itda_pkg::dab_ctl_type            dab_ctl,
   input  itda_pkg::dab_stat_type           dab_stat,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output itda_pkg::rsp_type                rsp_data
);
   import itda_pkg::*;

   localparam logic [POS_W-1:0] NDIG = POS_W'(NUM_DIGITS);

   emit_state_type   state_ff, state_in;
   logic             neg_ff;
   logic [POS_W-1:0] mind_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             started_ff, started_in;
   logic             valid_ff, valid_in;
   rsp_type          data_ff, data_in;

   logic       out_free;
   logic       in_bcd;
   logic [3:0] digit;
   logic       skip;
   logic       step;
   logic       emit;
   logic       pos_zero;

   assign out_free = !valid_ff || rsp_ready;
   assign in_bcd   = (pos_ff < NDIG);
   assign digit    = in_bcd ? dab_stat.top_digit : 4'd0;
   assign pos_zero = (pos_ff == '0);
   assign skip     = !started_ff && (digit == 4'd0) && (pos_ff >= mind_ff) && !pos_zero;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (dab_stat.done) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (!skip && out_free && pos_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: stepping through digit positions and loading the output word
   always_comb begin
      step    = 1'b0;
      emit    = 1'b0;
      data_in = data_ff;
      case (state_ff)
         ST_SIGN: begin
            emit    = out_free;
            data_in = '{character: CHAR_MINUS, last: 1'b0};
         end
         ST_DIGITS: begin
            step    = skip || out_free;
            emit    = !skip && out_free;
            data_in = '{character: CHAR_ZERO + {4'd0, digit}, last: pos_zero};
         end
         default: begin
            step = 1'b0;
         end
      endcase
   end

   assign dab_ctl.load        = start && (state_ff == ST_IDLE);
   assign dab_ctl.shift_digit = step && in_bcd;

   // Position counter starts at the widest of the pad and the digit field
   always_comb begin
      pos_in     = pos_ff;
      started_in = started_ff;
      if (state_ff == ST_IDLE) begin
         pos_in     = ((min_digits > NDIG) ? min_digits : NDIG) - POS_W'(1);
         started_in = 1'b0;
      end else if (step) begin
         pos_in     = pos_ff - POS_W'(1);
         started_in = started_ff || !skip;
      end
   end

   // Hold the output word until it is taken
   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      started_ff <= started_in;
      if (emit) begin
         data_ff <= data_in;
      end
      if (state_ff == ST_IDLE) begin
         neg_ff  <= neg;
         mind_ff <= min_digits;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign idle      = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: hw/rtl/integer_to_decimal_ascii_top.sv
// Integer to decimal ASCII formatter.
//
// Input channel (req_): one word holds a 64-bit value, a signed mode bit and
// a minimum digit count. Only the low VALUE_WIDTH bits of the value are used,
// sign-extended in signed mode. Output channel (rsp_): one ASCII character per
// word, '-' first for a negative signed value, then leading '0' padding up to
// the minimum count (saturated at MAX_PAD_DIGITS), then the digits, most
// significant first; last marks the final character of each number.
//
// Timing: after a word is accepted the binary value is shifted into a BCD
// register one bit per cycle. The sequencer then emits the sign (if any)
// and steps through each digit position from max(min_digits, NUM_DIGITS)-1
// down to 0, skipped leading zeros included. req_ready is high only while
// no number is in progress.
// A stalled rsp_ready holds the output register; the sequencer still steps
// over dropped leading zeros and then waits on the next character to emit.
// Reset (synchronous, active high) drops any number in progress and the
// pending output word.
module integer_to_decimal_ascii_top #(
   parameter int unsigned VALUE_WIDTH    = 64,
   parameter int unsigned MAX_PAD_DIGITS = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itda_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itda_pkg::rsp_type rsp_data
);
   import itda_pkg::*;

   localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   neg;
   logic [POS_W-1:0]       mind_sat;
   logic                   idle;
   dab_ctl_type            dab_ctl;
   dab_stat_type           dab_stat;

   // Form the magnitude and clamp the pad count
   assign raw      = req_data.value[VALUE_WIDTH-1:0];
   assign neg      = req_data.signed_mode && raw[VALUE_WIDTH-1];
   assign mag      = neg ? ({VALUE_WIDTH{1'b0}} - raw) : raw;
   assign mind_sat = (req_data.min_digits > POS_W'(MAX_PAD_DIGITS)) ?
                     POS_W'(MAX_PAD_DIGITS) : req_data.min_digits;

   assign req_ready = idle;

   itda_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .ctl   (dab_ctl),
      .mag   (mag),
      .stat  (dab_stat)
   );

   itda_emit #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (req_valid),
      .neg        (neg),
      .min_digits (mind_sat),
      .idle       (idle),
      .dab_ctl    (dab_ctl),
      .dab_stat   (dab_stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // A number in progress blocks the next word
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted word did not make the block busy");

   // Going idle coincides with the final character sitting in the output
   assert property (@(posedge clock) disable iff (reset)
      ($rose(req_ready) && !$past(reset)) |-> (rsp_valid && rsp_data.last))
      else $error("block went idle without a final character");

   // Only the sign and decimal digits leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.character >= CHAR_ZERO &&
                      rsp_data.character <= CHAR_ZERO + 8'd9) ||
                     rsp_data.character == CHAR_MINUS))
      else $error("character outside sign and digit range");

endmodule
